[rtl/lbt_pkg.sv]
// ============================================================================
// Label boundary tracer package
// Shared types, codes and small constant tables for the boundary tracer.
// ============================================================================
`default_nettype none

package lbt_pkg;

	// Input command codes.
	localparam logic [1:0] CMD_WRITE = 2'd0;
	localparam logic [1:0] CMD_START = 2'd1;
	localparam logic [1:0] CMD_STEP  = 2'd2;

	// Result status codes.
	localparam logic [1:0] ST_POINT  = 2'd0;
	localparam logic [1:0] ST_DONE   = 2'd1;
	localparam logic [1:0] ST_ABSENT = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] REG_FOUR = 2'd0;
	localparam logic [1:0] REG_ROWS = 2'd1;
	localparam logic [1:0] REG_COLS = 2'd2;

	// Heading codes.
	localparam logic [1:0] HEAD_EAST = 2'd1;

	// Neighbourhood slots: slot = (drow + 1) * 3 + (dcol + 1).
	localparam logic [3:0] NB_NE     = 4'd2;
	localparam logic [3:0] NB_CENTER = 4'd4;
	localparam logic [3:0] NB_E      = 4'd5;
	localparam logic [3:0] NB_S      = 4'd7;
	localparam logic [3:0] NB_SE     = 4'd8;
	localparam logic [3:0] NB_LAST   = 4'd8;

	localparam logic [17:0] COUNT_MAX = 18'h3FFFF;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_TRACE = 2'd1,
		PH_DONE  = 2'd2
	} phase_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_SRCH_GO,
		S_SRCH_RD,
		S_SRCH_EVAL,
		S_STEP_RD,
		S_STEP_EVAL,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic [15:0] r;
		logic [15:0] c;
	} pt_t;

	typedef struct packed {
		logic wr_pix;
		logic start_lat;
		logic scan_init;
		logic srch_init;
		logic fetch_init;
		logic fetch_srch;
		logic srch_eval;
		logic step_eval;
		logic res_absent;
		logic res_done1;
		logic emit_pop;
	} ctl_t;

	typedef struct packed {
		logic scan_done;
		logic found;
		logic fetch_done;
		logic srch_stop;
		logic tracing;
		logic res_empty;
		logic res_last;
	} stat_t;

	// Moore search order, relative to a north heading.
	function automatic int moore_row(input int i);
		int r;
		case (i)
			0: r = 2;
			1: r = 1;
			2: r = 0;
			3: r = 0;
			4: r = 0;
			5: r = 1;
			6: r = 2;
			default: r = 2;
		endcase
		return r;
	endfunction

	function automatic int moore_col(input int i);
		int c;
		case (i)
			0: c = 0;
			1: c = 0;
			2: c = 0;
			3: c = 1;
			4: c = 2;
			5: c = 2;
			6: c = 2;
			default: c = 1;
		endcase
		return c;
	endfunction

	function automatic logic [1:0] moore_turn(input int i);
		logic [1:0] t;
		case (i)
			0: t = 2'd3;
			1: t = 2'd0;
			2: t = 2'd0;
			3: t = 2'd1;
			4: t = 2'd1;
			5: t = 2'd2;
			6: t = 2'd2;
			default: t = 2'd3;
		endcase
		return t;
	endfunction

	// Rotate a heading-relative offset (u is column, v is row) by k quarter
	// turns and return its neighbourhood slot.
	function automatic logic [3:0] local_idx(input logic [1:0] k, input int u, input int v);
		int a;
		int b;
		int t;
		a = u;
		b = v;
		for (int i = 0; i < 3; i++) begin
			if (i < int'(k)) begin
				t = a;
				a = -b;
				b = t;
			end
		end
		return 4'((b + 1) * 3 + (a + 1));
	endfunction

	function automatic logic [15:0] off_row(input logic [3:0] j);
		logic [15:0] o;
		case (j)
			4'd0, 4'd1, 4'd2: o = 16'hFFFF;
			4'd6, 4'd7, 4'd8: o = 16'd1;
			default:          o = 16'd0;
		endcase
		return o;
	endfunction

	function automatic logic [15:0] off_col(input logic [3:0] j);
		logic [15:0] o;
		case (j)
			4'd0, 4'd3, 4'd6: o = 16'hFFFF;
			4'd2, 4'd5, 4'd8: o = 16'd1;
			default:          o = 16'd0;
		endcase
		return o;
	endfunction

	function automatic pt_t nb_pt(input pt_t p, input logic [3:0] j);
		pt_t q;
		q.r = p.r + off_row(j);
		q.c = p.c + off_col(j);
		return q;
	endfunction

endpackage

`default_nettype wire

[rtl/lbt_if.sv]
// ============================================================================
// Label boundary tracer channels
// Valid/ready channels for command beats and result beats.
// ============================================================================
`default_nettype none

interface lbt_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [7:0]  pixel_row;
	logic [7:0]  pixel_col;
	logic [15:0] label_value;

	modport source(output valid, cmd, pixel_row, pixel_col, label_value, input ready);
	modport sink(input valid, cmd, pixel_row, pixel_col, label_value, output ready);
endinterface

interface lbt_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] point_col;
	logic [7:0] point_row;
	logic [1:0] status;
	logic       last;

	modport source(output valid, point_col, point_row, status, last, input ready);
	modport sink(input valid, point_col, point_row, status, last, output ready);
endinterface

`default_nettype wire

[rtl/label_boundary_tracer.sv]
// ============================================================================
// Label boundary tracer
// Label image store with Moore and 4-connected boundary tracing.
// ============================================================================
// An advance in a trace reads the nine pixels around the current point, then
// offers its result beats; outside a trace it offers one done beat. A start
// scans rows x cols pixels, one per cycle, then fetches the neighbourhood of each
// box position until the start pixel is found or the box is exhausted. Each
// command runs alone; the next is taken the cycle after its last beat is accepted.
// Reset clears control and trace state; the image memory is not cleared.
`default_nettype none

module label_boundary_tracer #(
	parameter int MAX_ROWS   = 256,
	parameter int MAX_COLS   = 256,
	parameter int LABEL_BITS = 16
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	lbt_in_if.sink          in_ch,
	lbt_out_if.source       out_ch,
	input  wire logic       cfg_we,
	input  wire logic [1:0] cfg_index,
	input  wire logic [8:0] cfg_wdata
);

	lbt_pkg::ctl_t  ctl;
	lbt_pkg::stat_t stat;
	logic           in_ready;
	logic           out_valid;

	// The controller owns the handshakes; every command beat is taken only
	// in its idle state, and results are held in datapath registers until
	// each beat is taken.
	lbt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_cmd   (in_ch.cmd),
		.out_ready(out_ch.ready),
		.stat     (stat),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.ctl      (ctl)
	);

	// The datapath holds the image memory, bounding box, neighbourhood
	// fetch, trace state and the two result registers.
	lbt_datapath #(
		.MAX_ROWS  (MAX_ROWS),
		.MAX_COLS  (MAX_COLS),
		.LABEL_BITS(LABEL_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.stat      (stat),
		.in_row    (in_ch.pixel_row),
		.in_col    (in_ch.pixel_col),
		.in_label  (in_ch.label_value),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.out_col   (out_ch.point_col),
		.out_row   (out_ch.point_row),
		.out_status(out_ch.status),
		.out_last  (out_ch.last)
	);

	assign in_ch.ready  = in_ready;
	assign out_ch.valid = out_valid;

	// A result beat is never offered while a command can be taken.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("result offered while accepting commands");

	// A start command always leaves the idle state.
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ready && in_ch.cmd == lbt_pkg::CMD_START) |=> !in_ready)
		else $error("start command did not occupy the block");

	// After the final beat of a result set the block is ready again.
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ch.ready && out_ch.last) |=> in_ready)
		else $error("block not ready after last result beat");

endmodule

`default_nettype wire

[rtl/lbt_ram.sv]
// ============================================================================
// Label boundary tracer RAM
// Single-port RAM with a registered read.
// ============================================================================
`default_nettype none

module lbt_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 65536
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

`default_nettype wire

[rtl/lbt_datapath.sv]
// ============================================================================
// Label boundary tracer datapath
// Image memory, bounding-box scan, neighbourhood fetch and trace state.
// ============================================================================
`default_nettype none

module lbt_datapath #(
	parameter int MAX_ROWS   = 256,
	parameter int MAX_COLS   = 256,
	parameter int LABEL_BITS = 16
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire lbt_pkg::ctl_t  ctl,
	output lbt_pkg::stat_t      stat,
	input  wire logic [7:0]     in_row,
	input  wire logic [7:0]     in_col,
	input  wire logic [15:0]    in_label,
	input  wire logic           cfg_we,
	input  wire logic [1:0]     cfg_index,
	input  wire logic [8:0]     cfg_wdata,
	output logic      [7:0]     out_col,
	output logic      [7:0]     out_row,
	output logic      [1:0]     out_status,
	output logic                out_last
);

	localparam int RB = $clog2(MAX_ROWS);
	localparam int CB = $clog2(MAX_COLS);
	localparam int AW = RB + CB;

	// Configuration.
	logic       four_q;
	logic [8:0] rows_q, cols_q, er, ec;

	// Memory port.
	logic                  ram_we;
	logic [AW-1:0]         ram_addr;
	logic [LABEL_BITS-1:0] ram_rdata;

	// Scan.
	logic                  sact_q, sv_s1, found_q;
	logic [8:0]            sr_q, sc_q, sr_s1, sc_s1;
	logic [LABEL_BITS-1:0] label_q;
	logic                  match;

	// Box.
	logic [7:0] bminr_q, bmaxr_q, bminc_q, bmaxc_q;

	// Fetch.
	logic         fact_q, fv_s1, fin_s1;
	logic [3:0]   fcnt_q, fidx_s1;
	lbt_pkg::pt_t fbase_q, fnb;
	logic [8:0]   fg9_q;

	// Start search.
	logic [7:0]   pr_q, pc_q, fr_q, fc_q;
	logic         hf_q, center, cand, at_end;
	lbt_pkg::pt_t spos, sstart;

	// Trace state.
	lbt_pkg::phase_t phase_q;
	logic [1:0]      head_q;
	lbt_pkg::pt_t    cur_q, f0_q, f1_q, l0_q, l1_q;
	logic [17:0]     cnt_q;

	// Step evaluation.
	logic [1:0]   n, turn;
	logic [3:0]   i0, i1;
	lbt_pkg::pt_t p0, p1, f1_new, l0_new, l1_new, cur_new;
	logic [18:0]  sum;
	logic [17:0]  cnt_new;
	logic         close1, close2;
	int           mv;
	logic         mfound;

	// Results.
	logic [7:0] res_col_q [2];
	logic [7:0] res_row_q [2];
	logic [1:0] res_st_q  [2];
	logic       res_last_q [2];
	logic [1:0] res_n_q;
	logic       eidx_q;

	function automatic logic inbox(input lbt_pkg::pt_t p, input logic [7:0] r0,
			input logic [7:0] r1, input logic [7:0] c0, input logic [7:0] c1);
		return (p.r >= {8'd0, r0}) && (p.r <= {8'd0, r1}) &&
			(p.c >= {8'd0, c0}) && (p.c <= {8'd0, c1});
	endfunction

	assign er = (32'(rows_q) < MAX_ROWS) ? rows_q : 9'(MAX_ROWS);
	assign ec = (32'(cols_q) < MAX_COLS) ? cols_q : 9'(MAX_COLS);

	assign fnb = lbt_pkg::nb_pt(fbase_q, fcnt_q);

	always_comb begin
		ram_we = ctl.wr_pix && (32'(in_row) < MAX_ROWS) && (32'(in_col) < MAX_COLS);
		if (ctl.wr_pix) begin
			ram_addr = {RB'(in_row), CB'(in_col)};
		end else if (sact_q) begin
			ram_addr = {RB'(sr_q), CB'(sc_q)};
		end else begin
			ram_addr = {RB'(fnb.r), CB'(fnb.c)};
		end
	end

	lbt_ram #(
		.WIDTH(LABEL_BITS),
		.DEPTH(2 ** AW)
	) u_image (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(LABEL_BITS'(in_label)),
		.rdata(ram_rdata)
	);

	assign match = sv_s1 && (ram_rdata == label_q) && (label_q != '0);

	// Start-pixel search on the fetched neighbourhood.
	always_comb begin
		spos   = '{r: {8'd0, pr_q}, c: {8'd0, pc_q}};
		center = fg9_q[lbt_pkg::NB_CENTER];
		cand   = fg9_q[lbt_pkg::NB_E] | fg9_q[lbt_pkg::NB_S] |
			fg9_q[lbt_pkg::NB_SE] | fg9_q[lbt_pkg::NB_NE];
		at_end = (pc_q == bmaxc_q) && (pr_q == bmaxr_q);
		if (center && cand) begin
			sstart = spos;
		end else if (hf_q) begin
			sstart = '{r: {8'd0, fr_q}, c: {8'd0, fc_q}};
		end else begin
			sstart = spos;
		end
	end

	// One tracing step from the fetched neighbourhood.
	always_comb begin
		n      = 2'd0;
		i0     = lbt_pkg::NB_CENTER;
		i1     = lbt_pkg::NB_CENTER;
		turn   = 2'd0;
		mv     = 0;
		mfound = 1'b0;
		if (four_q) begin
			if (fg9_q[lbt_pkg::local_idx(head_q, -1, 0)]) begin
				n = 2'd1;
				i0 = lbt_pkg::local_idx(head_q, -1, 0);
				turn = 2'd3;
			end else if (fg9_q[lbt_pkg::local_idx(head_q, -1, 1)] &&
					!fg9_q[lbt_pkg::local_idx(head_q, 0, 1)]) begin
				n = 2'd1;
				i0 = lbt_pkg::local_idx(head_q, -1, 1);
				turn = 2'd2;
			end else if (fg9_q[lbt_pkg::local_idx(head_q, -1, -1)]) begin
				if (fg9_q[lbt_pkg::local_idx(head_q, 0, -1)]) begin
					n = 2'd2;
					i0 = lbt_pkg::local_idx(head_q, 0, -1);
					i1 = lbt_pkg::local_idx(head_q, -1, -1);
				end else begin
					n = 2'd1;
					i0 = lbt_pkg::local_idx(head_q, -1, -1);
				end
				turn = 2'd0;
			end else if (fg9_q[lbt_pkg::local_idx(head_q, 0, -1)]) begin
				n = 2'd1;
				i0 = lbt_pkg::local_idx(head_q, 0, -1);
				turn = 2'd1;
			end else begin
				turn = 2'd2;
			end
		end else begin
			for (int i = 0; i < 8; i++) begin
				if (!mfound && fg9_q[lbt_pkg::local_idx(head_q, lbt_pkg::moore_col(i) - 1,
						lbt_pkg::moore_row(i) - 1)]) begin
					mv = i;
					mfound = 1'b1;
				end
			end
			n = 2'd1;
			i0 = lbt_pkg::local_idx(head_q, lbt_pkg::moore_col(mv) - 1,
				lbt_pkg::moore_row(mv) - 1);
			turn = lbt_pkg::moore_turn(mv);
		end

		p0 = lbt_pkg::nb_pt(cur_q, i0);
		p1 = lbt_pkg::nb_pt(cur_q, i1);

		sum = {1'b0, cnt_q} + {17'd0, n};
		cnt_new = (sum > {1'b0, lbt_pkg::COUNT_MAX}) ? lbt_pkg::COUNT_MAX : sum[17:0];
		f1_new = ((n != 2'd0) && (cnt_q == 18'd1)) ? p0 : f1_q;
		unique case (n)
			2'd1: begin
				l0_new = l1_q;
				l1_new = p0;
				cur_new = p0;
			end
			2'd2: begin
				l0_new = p0;
				l1_new = p1;
				cur_new = p1;
			end
			default: begin
				l0_new = l0_q;
				l1_new = l1_q;
				cur_new = cur_q;
			end
		endcase
		close1 = (cnt_new > 18'd3) && (l1_new == f1_new) && (l0_new == f0_q);
		close2 = (cnt_new > 18'd3) && (n == 2'd2) && (p0 == f1_new) && (l1_q == f0_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			four_q  <= 1'b0;
			rows_q  <= 9'd256;
			cols_q  <= 9'd256;
			label_q <= '0;
			sact_q  <= 1'b0;
			sv_s1   <= 1'b0;
			sr_q    <= '0;
			sc_q    <= '0;
			sr_s1   <= '0;
			sc_s1   <= '0;
			found_q <= 1'b0;
			bminr_q <= '0;
			bmaxr_q <= '0;
			bminc_q <= '0;
			bmaxc_q <= '0;
			fact_q  <= 1'b0;
			fv_s1   <= 1'b0;
			fin_s1  <= 1'b0;
			fcnt_q  <= '0;
			fidx_s1 <= '0;
			fbase_q <= '0;
			fg9_q   <= '0;
			pr_q    <= '0;
			pc_q    <= '0;
			fr_q    <= '0;
			fc_q    <= '0;
			hf_q    <= 1'b0;
			phase_q <= lbt_pkg::PH_IDLE;
			head_q  <= lbt_pkg::HEAD_EAST;
			cur_q   <= '0;
			f0_q    <= '0;
			f1_q    <= '0;
			l0_q    <= '0;
			l1_q    <= '0;
			cnt_q   <= '0;
			res_n_q <= '0;
			eidx_q  <= 1'b0;
			for (int i = 0; i < 2; i++) begin
				res_col_q[i]  <= '0;
				res_row_q[i]  <= '0;
				res_st_q[i]   <= lbt_pkg::ST_POINT;
				res_last_q[i] <= 1'b0;
			end
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					lbt_pkg::REG_FOUR: four_q <= cfg_wdata[0];
					lbt_pkg::REG_ROWS: rows_q <= cfg_wdata;
					lbt_pkg::REG_COLS: cols_q <= cfg_wdata;
					default: ;
				endcase
			end

			if (ctl.start_lat) begin
				label_q <= LABEL_BITS'(in_label);
			end

			// Raster scan of the image area for the label's bounding box.
			if (ctl.scan_init) begin
				sr_q    <= '0;
				sc_q    <= '0;
				sact_q  <= (er != 9'd0) && (ec != 9'd0);
				found_q <= 1'b0;
			end else if (sact_q) begin
				if (sc_q == ec - 9'd1) begin
					sc_q <= '0;
					if (sr_q == er - 9'd1) begin
						sact_q <= 1'b0;
					end else begin
						sr_q <= sr_q + 9'd1;
					end
				end else begin
					sc_q <= sc_q + 9'd1;
				end
			end
			sv_s1 <= sact_q;
			sr_s1 <= sr_q;
			sc_s1 <= sc_q;
			if (match) begin
				found_q <= 1'b1;
				bmaxr_q <= sr_s1[7:0];
				if (!found_q) begin
					bminr_q <= sr_s1[7:0];
					bminc_q <= sc_s1[7:0];
					bmaxc_q <= sc_s1[7:0];
				end else begin
					if (sc_s1[7:0] < bminc_q) begin
						bminc_q <= sc_s1[7:0];
					end
					if (sc_s1[7:0] > bmaxc_q) begin
						bmaxc_q <= sc_s1[7:0];
					end
				end
			end

			// Neighbourhood fetch: nine reads around the base point.
			if (ctl.fetch_init) begin
				fact_q  <= 1'b1;
				fcnt_q  <= '0;
				fbase_q <= ctl.fetch_srch ? spos : cur_q;
			end else if (fact_q) begin
				fcnt_q <= fcnt_q + 4'd1;
				if (fcnt_q == lbt_pkg::NB_LAST) begin
					fact_q <= 1'b0;
				end
			end
			fv_s1   <= fact_q && !ctl.fetch_init;
			fidx_s1 <= fcnt_q;
			fin_s1  <= inbox(fnb, bminr_q, bmaxr_q, bminc_q, bmaxc_q);
			if (fv_s1) begin
				fg9_q[fidx_s1] <= fin_s1 && (ram_rdata != '0);
			end

			if (ctl.srch_init) begin
				pr_q <= bminr_q;
				pc_q <= bminc_q;
				hf_q <= 1'b0;
			end

			if (ctl.srch_eval) begin
				if (center && !hf_q) begin
					hf_q <= 1'b1;
					fr_q <= pr_q;
					fc_q <= pc_q;
				end
				if ((center && cand) || at_end) begin
					head_q   <= lbt_pkg::HEAD_EAST;
					cnt_q    <= 18'd1;
					phase_q  <= (center && cand) ? lbt_pkg::PH_TRACE : lbt_pkg::PH_DONE;
					cur_q    <= sstart;
					f0_q     <= sstart;
					f1_q     <= sstart;
					l0_q     <= sstart;
					l1_q     <= sstart;
					res_n_q  <= 2'd1;
					eidx_q   <= 1'b0;
					res_col_q[0]  <= sstart.c[7:0];
					res_row_q[0]  <= sstart.r[7:0];
					res_st_q[0]   <= lbt_pkg::ST_POINT;
					res_last_q[0] <= 1'b1;
				end else if (pc_q == bmaxc_q) begin
					pc_q <= bminc_q;
					pr_q <= pr_q + 8'd1;
				end else begin
					pc_q <= pc_q + 8'd1;
				end
			end

			if (ctl.step_eval) begin
				head_q <= head_q + turn;
				cnt_q  <= cnt_new;
				f1_q   <= f1_new;
				l0_q   <= l0_new;
				l1_q   <= l1_new;
				cur_q  <= cur_new;
				eidx_q <= 1'b0;
				if (close1 && (n == 2'd2)) begin
					// The first point is kept, the second closes the loop.
					res_n_q       <= 2'd2;
					res_col_q[0]  <= p0.c[7:0];
					res_row_q[0]  <= p0.r[7:0];
					res_st_q[0]   <= lbt_pkg::ST_POINT;
					res_last_q[0] <= 1'b0;
					res_col_q[1]  <= '0;
					res_row_q[1]  <= '0;
					res_st_q[1]   <= lbt_pkg::ST_DONE;
					res_last_q[1] <= 1'b1;
					phase_q       <= lbt_pkg::PH_DONE;
				end else if (close1 || close2) begin
					res_n_q       <= 2'd1;
					res_col_q[0]  <= '0;
					res_row_q[0]  <= '0;
					res_st_q[0]   <= lbt_pkg::ST_DONE;
					res_last_q[0] <= 1'b1;
					phase_q       <= lbt_pkg::PH_DONE;
				end else begin
					res_n_q       <= n;
					res_col_q[0]  <= p0.c[7:0];
					res_row_q[0]  <= p0.r[7:0];
					res_st_q[0]   <= lbt_pkg::ST_POINT;
					res_last_q[0] <= (n == 2'd1);
					res_col_q[1]  <= p1.c[7:0];
					res_row_q[1]  <= p1.r[7:0];
					res_st_q[1]   <= lbt_pkg::ST_POINT;
					res_last_q[1] <= 1'b1;
				end
			end

			if (ctl.res_absent || ctl.res_done1) begin
				res_n_q       <= 2'd1;
				eidx_q        <= 1'b0;
				res_col_q[0]  <= '0;
				res_row_q[0]  <= '0;
				res_st_q[0]   <= ctl.res_absent ? lbt_pkg::ST_ABSENT : lbt_pkg::ST_DONE;
				res_last_q[0] <= 1'b1;
				if (ctl.res_absent) begin
					phase_q <= lbt_pkg::PH_IDLE;
				end
			end

			if (ctl.emit_pop) begin
				eidx_q <= 1'b1;
			end
		end
	end

	always_comb begin
		stat.scan_done  = !sact_q && !sv_s1;
		stat.found      = found_q;
		stat.fetch_done = !fact_q && !fv_s1;
		stat.srch_stop  = (center && cand) || at_end;
		stat.tracing    = (phase_q == lbt_pkg::PH_TRACE);
		stat.res_empty  = (res_n_q == 2'd0);
		stat.res_last   = res_last_q[eidx_q];
	end

	assign out_col    = res_col_q[eidx_q];
	assign out_row    = res_row_q[eidx_q];
	assign out_status = res_st_q[eidx_q];
	assign out_last   = res_last_q[eidx_q];

endmodule

`default_nettype wire

[rtl/lbt_ctrl.sv]
// ============================================================================
// Label boundary tracer controller
// Sequences commands through scan, search, step and result delivery.
// ============================================================================
`default_nettype none

module lbt_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	input  wire logic [1:0]     in_cmd,
	input  wire logic           out_ready,
	input  wire lbt_pkg::stat_t stat,
	output logic                in_ready,
	output logic                out_valid,
	output lbt_pkg::ctl_t       ctl
);

	lbt_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lbt_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		ctl       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			lbt_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					unique case (in_cmd)
						lbt_pkg::CMD_WRITE: ctl.wr_pix = 1'b1;
						lbt_pkg::CMD_START: begin
							ctl.start_lat = 1'b1;
							ctl.scan_init = 1'b1;
							state_d = lbt_pkg::S_SCAN;
						end
						lbt_pkg::CMD_STEP: begin
							if (stat.tracing) begin
								ctl.fetch_init = 1'b1;
								state_d = lbt_pkg::S_STEP_RD;
							end else begin
								ctl.res_done1 = 1'b1;
								state_d = lbt_pkg::S_EMIT;
							end
						end
						default: ;
					endcase
				end
			end
			lbt_pkg::S_SCAN: begin
				if (stat.scan_done) begin
					if (stat.found) begin
						ctl.srch_init = 1'b1;
						state_d = lbt_pkg::S_SRCH_GO;
					end else begin
						ctl.res_absent = 1'b1;
						state_d = lbt_pkg::S_EMIT;
					end
				end
			end
			lbt_pkg::S_SRCH_GO: begin
				ctl.fetch_init = 1'b1;
				ctl.fetch_srch = 1'b1;
				state_d = lbt_pkg::S_SRCH_RD;
			end
			lbt_pkg::S_SRCH_RD: begin
				if (stat.fetch_done) begin
					state_d = lbt_pkg::S_SRCH_EVAL;
				end
			end
			lbt_pkg::S_SRCH_EVAL: begin
				ctl.srch_eval = 1'b1;
				state_d = stat.srch_stop ? lbt_pkg::S_EMIT : lbt_pkg::S_SRCH_GO;
			end
			lbt_pkg::S_STEP_RD: begin
				if (stat.fetch_done) begin
					state_d = lbt_pkg::S_STEP_EVAL;
				end
			end
			lbt_pkg::S_STEP_EVAL: begin
				ctl.step_eval = 1'b1;
				state_d = lbt_pkg::S_EMIT;
			end
			lbt_pkg::S_EMIT: begin
				if (stat.res_empty) begin
					state_d = lbt_pkg::S_IDLE;
				end else begin
					out_valid = 1'b1;
					if (out_ready) begin
						ctl.emit_pop = 1'b1;
						if (stat.res_last) begin
							state_d = lbt_pkg::S_IDLE;
						end
					end
				end
			end
			default: state_d = lbt_pkg::S_IDLE;
		endcase
	end

endmodule

`default_nettype wire
